### hdl/nbhu_pkg.sv
// Shared types, codes and the micro-op table of the Newmark-beta history update block.
`timescale 1ns / 1ps
`default_nettype none
package nbhu_pkg;

    localparam int WORD_W  = 48;
    localparam int HALF_W  = 24;
    localparam int PROD_W  = 2 * WORD_W;
    localparam int SUM_W   = WORD_W + 2;
    localparam int IDX_W   = 10;
    localparam int FUNC_W  = 3;
    localparam int NUM_COEF = 8;
    localparam int CIDX_W  = 3;
    localparam int STEP_W  = 4;

    // item kinds
    localparam logic [FUNC_W-1:0] F_INIT_DISP = 3'd0;
    localparam logic [FUNC_W-1:0] F_INIT_VEL  = 3'd1;
    localparam logic [FUNC_W-1:0] F_INIT_ACC  = 3'd2;
    localparam logic [FUNC_W-1:0] F_EFF_LOAD  = 3'd3;
    localparam logic [FUNC_W-1:0] F_UPDATE    = 3'd4;

    // multiplier A operand
    localparam logic [3:0] A_VB  = 4'd0;
    localparam logic [3:0] A_VC  = 4'd1;
    localparam logic [3:0] A_U1  = 4'd2;
    localparam logic [3:0] A_V1  = 4'd3;
    localparam logic [3:0] A_W1  = 4'd4;
    localparam logic [3:0] A_DU  = 4'd5;
    localparam logic [3:0] A_SM  = 4'd6;
    localparam logic [3:0] A_SD  = 4'd7;
    localparam logic [3:0] A_ACC = 4'd8;

    // multiplier B operand: coefficient a0..a7, or a value field
    localparam logic [3:0] B_C0 = 4'd0;
    localparam logic [3:0] B_C1 = 4'd1;
    localparam logic [3:0] B_C2 = 4'd2;
    localparam logic [3:0] B_C3 = 4'd3;
    localparam logic [3:0] B_C4 = 4'd4;
    localparam logic [3:0] B_C5 = 4'd5;
    localparam logic [3:0] B_C6 = 4'd6;
    localparam logic [3:0] B_C7 = 4'd7;
    localparam logic [3:0] B_VB = 4'd8;
    localparam logic [3:0] B_VC = 4'd9;

    // starting value of a sum
    localparam logic [1:0] BASE_ZERO = 2'd0;
    localparam logic [1:0] BASE_VA   = 2'd1;
    localparam logic [1:0] BASE_V1   = 2'd2;

    // sum destinations
    localparam logic [2:0] D_DIAG = 3'd0;
    localparam logic [2:0] D_SM   = 3'd1;
    localparam logic [2:0] D_SD   = 3'd2;
    localparam logic [2:0] D_EFF  = 3'd3;
    localparam logic [2:0] D_ACC  = 3'd4;
    localparam logic [2:0] D_VEL  = 3'd5;

    // one multiply-accumulate step
    typedef struct packed {
        logic [3:0] a_sel;
        logic [3:0] b_sel;
        logic       first;  // sum starts from base
        logic [1:0] base;
        logic       neg;    // subtract the product
        logic       last;   // clamp sum and store to dst
        logic [2:0] dst;
        logic       cut;    // program ends here for a constrained freedom
        logic       stop;   // program ends here
    } t_uop;

    // controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       mem_rd;
        logic       load_hist;
        logic       mul_ld;
        logic       pp_en;
        logic [1:0] pp_sel;
        logic       rnd_en;
        logic       acc_en;
        t_uop       uop;
        logic       wb_en;
        logic       out_load;
        logic       clr_en;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              cons;
        logic              out_free;
    } t_stat;

    function automatic t_uop f_mk(input logic [3:0] a, input logic [3:0] b,
                                  input logic first, input logic [1:0] base,
                                  input logic neg, input logic last,
                                  input logic [2:0] dst, input logic cut,
                                  input logic stop);
        t_uop u;
        u.a_sel = a;  u.b_sel = b;  u.first = first; u.base = base;
        u.neg = neg;  u.last = last; u.dst = dst;    u.cut = cut;
        u.stop = stop;
        return u;
    endfunction

    // micro-program: effective load (upd = 0) and update (upd = 1)
    function automatic t_uop f_uop(input logic upd, input logic [STEP_W-1:0] step);
        t_uop u;
        u = f_mk(A_VB, B_C0, 1'b0, BASE_ZERO, 1'b0, 1'b0, D_DIAG, 1'b0, 1'b1);
        if (!upd) begin
            case (step)
                4'd0: u = f_mk(A_VB, B_C0, 1'b1, BASE_ZERO, 1'b0, 1'b0, D_DIAG, 1'b0, 1'b0);
                4'd1: u = f_mk(A_VC, B_C1, 1'b0, BASE_ZERO, 1'b0, 1'b1, D_DIAG, 1'b1, 1'b0);
                4'd2: u = f_mk(A_U1, B_C0, 1'b1, BASE_ZERO, 1'b0, 1'b0, D_SM,   1'b0, 1'b0);
                4'd3: u = f_mk(A_V1, B_C2, 1'b0, BASE_ZERO, 1'b0, 1'b0, D_SM,   1'b0, 1'b0);
                4'd4: u = f_mk(A_W1, B_C3, 1'b0, BASE_ZERO, 1'b0, 1'b1, D_SM,   1'b0, 1'b0);
                4'd5: u = f_mk(A_U1, B_C1, 1'b1, BASE_ZERO, 1'b0, 1'b0, D_SD,   1'b0, 1'b0);
                4'd6: u = f_mk(A_V1, B_C4, 1'b0, BASE_ZERO, 1'b0, 1'b0, D_SD,   1'b0, 1'b0);
                4'd7: u = f_mk(A_W1, B_C5, 1'b0, BASE_ZERO, 1'b0, 1'b1, D_SD,   1'b0, 1'b0);
                4'd8: u = f_mk(A_SM, B_VB, 1'b1, BASE_VA,   1'b0, 1'b0, D_EFF,  1'b0, 1'b0);
                4'd9: u = f_mk(A_SD, B_VC, 1'b0, BASE_ZERO, 1'b0, 1'b1, D_EFF,  1'b0, 1'b1);
                default: u.stop = 1'b1;
            endcase
        end else begin
            case (step)
                4'd0: u = f_mk(A_DU,  B_C0, 1'b1, BASE_ZERO, 1'b0, 1'b0, D_ACC, 1'b0, 1'b0);
                4'd1: u = f_mk(A_V1,  B_C2, 1'b0, BASE_ZERO, 1'b1, 1'b0, D_ACC, 1'b0, 1'b0);
                4'd2: u = f_mk(A_W1,  B_C3, 1'b0, BASE_ZERO, 1'b1, 1'b1, D_ACC, 1'b0, 1'b0);
                4'd3: u = f_mk(A_ACC, B_C7, 1'b1, BASE_V1,   1'b0, 1'b0, D_VEL, 1'b0, 1'b0);
                4'd4: u = f_mk(A_W1,  B_C6, 1'b0, BASE_ZERO, 1'b0, 1'b1, D_VEL, 1'b0, 1'b1);
                default: u.stop = 1'b1;
            endcase
        end
        return u;
    endfunction

endpackage
`default_nettype wire

### hdl/nbhu_datapath.sv
// Datapath: coefficient registers, history memories, shared multiplier and sum unit.
`timescale 1ns / 1ps
`default_nettype none
module nbhu_datapath #(
    parameter int DOF_DEPTH = 1024,
    parameter int FRAC_BITS = 24,
    parameter int AW        = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [nbhu_pkg::CIDX_W-1:0]   i_cfg_index,
    input  wire logic [nbhu_pkg::WORD_W-1:0]   i_cfg_data,
    input  wire logic [159:0]                  i_in_data,  // dof_index, constrained, value_a/b/c
    input  wire logic [nbhu_pkg::FUNC_W-1:0]   i_in_func,
    input  wire nbhu_pkg::t_cmd                i_cmd,
    input  wire logic [AW-1:0]                 i_clr_addr,
    output nbhu_pkg::t_stat                    o_stat,
    output logic [191:0]                       o_out_data, // eff_load, diag_add, new_acc, new_vel
    output logic [1:0]                         o_out_user, // skipped, saturated
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready
);
    import nbhu_pkg::*;

    localparam logic [PROD_W-1:0] RND    = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [PROD_W-1:0] LIM_P  = PROD_W'((64'd1 << (WORD_W - 1)) - 64'd1);
    localparam logic [PROD_W-1:0] LIM_N  = PROD_W'(64'd1 << (WORD_W - 1));
    localparam logic signed [SUM_W-1:0] SMAX = SUM_W'((64'd1 << (WORD_W - 1)) - 64'd1);
    localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);
    localparam int EXT_W = AW + IDX_W;

    // captured item
    logic [IDX_W-1:0]  r_idx;
    logic              r_cons;
    logic [FUNC_W-1:0] r_func;
    logic [WORD_W-1:0] r_va, r_vb, r_vc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_idx  <= i_in_data[9:0];
            r_cons <= i_in_data[10];
            r_va   <= i_in_data[58:11];
            r_vb   <= i_in_data[106:59];
            r_vc   <= i_in_data[154:107];
            r_func <= i_in_func;
        end
    end

    // address and range check
    logic [EXT_W-1:0] ext_idx;
    logic [AW-1:0]    addr;
    logic             ok;
    assign ext_idx = {{AW{1'b0}}, r_idx};
    assign addr    = ext_idx[AW-1:0];
    assign ok      = ({1'b0, ext_idx} < (EXT_W + 1)'(DOF_DEPTH));

    // coefficient registers
    logic [WORD_W-1:0] r_coef [NUM_COEF];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEF; k++) r_coef[k] <= '0;
        end else if (i_cfg_we) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    // history memories
    logic [WORD_W-1:0] r_mem_disp [DOF_DEPTH];
    logic [WORD_W-1:0] r_mem_vel  [DOF_DEPTH];
    logic [WORD_W-1:0] r_mem_acc  [DOF_DEPTH];
    logic [WORD_W-1:0] r_rd_disp, r_rd_vel, r_rd_acc;
    logic [WORD_W-1:0] r_acc, r_vel;
    logic [AW-1:0]     waddr;
    logic              we_disp, we_vel, we_acc, upd;
    logic [WORD_W-1:0] wd_disp, wd_vel, wd_acc, u_sol;

    assign upd     = (r_func == F_UPDATE);
    assign u_sol   = r_cons ? '0 : r_va;
    assign waddr   = i_cmd.clr_en ? i_clr_addr : addr;
    assign we_disp = i_cmd.clr_en ||
                     (i_cmd.wb_en && ok && (r_func == F_INIT_DISP || upd));
    assign we_vel  = i_cmd.clr_en ||
                     (i_cmd.wb_en && ok && (r_func == F_INIT_VEL || upd));
    assign we_acc  = i_cmd.clr_en ||
                     (i_cmd.wb_en && ok && (r_func == F_INIT_ACC || upd));
    assign wd_disp = i_cmd.clr_en ? '0 : (upd ? u_sol : r_va);
    assign wd_vel  = i_cmd.clr_en ? '0 : (upd ? r_vel : r_va);
    assign wd_acc  = i_cmd.clr_en ? '0 : (upd ? r_acc : r_va);

    always_ff @(posedge i_clk) begin
        if (we_disp) r_mem_disp[waddr] <= wd_disp;
        if (i_cmd.mem_rd) r_rd_disp <= r_mem_disp[addr];
    end
    always_ff @(posedge i_clk) begin
        if (we_vel) r_mem_vel[waddr] <= wd_vel;
        if (i_cmd.mem_rd) r_rd_vel <= r_mem_vel[addr];
    end
    always_ff @(posedge i_clk) begin
        if (we_acc) r_mem_acc[waddr] <= wd_acc;
        if (i_cmd.mem_rd) r_rd_acc <= r_mem_acc[addr];
    end

    // history words and saturated displacement step
    logic [WORD_W-1:0]        r_u1, r_v1, r_w1, r_du;
    logic signed [WORD_W:0]   du_full;
    logic                     du_hi, du_lo;
    assign du_full = $signed({u_sol[WORD_W-1], u_sol})
                   - $signed({(ok ? r_rd_disp[WORD_W-1] : 1'b0),
                              (ok ? r_rd_disp : {WORD_W{1'b0}})});
    assign du_hi   = (du_full > $signed((WORD_W + 1)'(SMAX)));
    assign du_lo   = (du_full < $signed((WORD_W + 1)'(SMIN)));

    // multiplier operands
    logic [WORD_W-1:0] op_a, op_b;
    logic [WORD_W-1:0] r_sm, r_sd, r_diag, r_eff;
    always_comb begin
        case (i_cmd.uop.a_sel)
            A_VB:    op_a = r_vb;
            A_VC:    op_a = r_vc;
            A_U1:    op_a = r_u1;
            A_V1:    op_a = r_v1;
            A_W1:    op_a = r_w1;
            A_DU:    op_a = r_du;
            A_SM:    op_a = r_sm;
            A_SD:    op_a = r_sd;
            A_ACC:   op_a = r_acc;
            default: op_a = '0;
        endcase
        case (i_cmd.uop.b_sel)
            B_VB:    op_b = r_vb;
            B_VC:    op_b = r_vc;
            default: op_b = r_coef[i_cmd.uop.b_sel[CIDX_W-1:0]];
        endcase
    end

    // magnitude product over four 24x24 partial products
    logic [WORD_W-1:0] r_ma, r_mb;
    logic              r_neg;
    logic [PROD_W-1:0] r_pp;
    logic [HALF_W-1:0] px, py;
    logic [WORD_W-1:0] pp;
    logic [PROD_W-1:0] pp_sh;
    assign px = i_cmd.pp_sel[1] ? r_ma[WORD_W-1:HALF_W] : r_ma[HALF_W-1:0];
    assign py = i_cmd.pp_sel[0] ? r_mb[WORD_W-1:HALF_W] : r_mb[HALF_W-1:0];
    assign pp = px * py;
    always_comb begin
        case (i_cmd.pp_sel)
            2'd0:    pp_sh = PROD_W'(pp);
            2'd3:    pp_sh = PROD_W'(pp) << (2 * HALF_W);
            default: pp_sh = PROD_W'(pp) << HALF_W;
        endcase
    end

    // rounding and saturation of the product
    logic [PROD_W-1:0] q, lim;
    logic              q_sat;
    logic [WORD_W-1:0] q_mag;
    assign q     = (r_pp + RND) >> FRAC_BITS;
    assign lim   = r_neg ? LIM_N : LIM_P;
    assign q_sat = (q > lim);
    assign q_mag = q_sat ? lim[WORD_W-1:0] : q[WORD_W-1:0];

    // sum unit
    logic [WORD_W-1:0]      r_prod;
    logic signed [SUM_W-1:0] r_sum, s_base, s_cur, s_next;
    logic                    s_hi, s_lo;
    logic [WORD_W-1:0]       s_clamp;
    always_comb begin
        case (i_cmd.uop.base)
            BASE_VA: s_base = SUM_W'($signed(r_va));
            BASE_V1: s_base = SUM_W'($signed(r_v1));
            default: s_base = '0;
        endcase
    end
    assign s_cur   = i_cmd.uop.first ? s_base : r_sum;
    assign s_next  = i_cmd.uop.neg ? s_cur - SUM_W'($signed(r_prod))
                                   : s_cur + SUM_W'($signed(r_prod));
    assign s_hi    = (s_next > SMAX);
    assign s_lo    = (s_next < SMIN);
    assign s_clamp = s_hi ? SMAX[WORD_W-1:0] : (s_lo ? SMIN[WORD_W-1:0] : s_next[WORD_W-1:0]);

    logic r_sat;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sat <= 1'b0;
            r_diag <= '0; r_eff <= '0; r_acc <= '0; r_vel <= '0;
        end
        if (i_cmd.load_hist) begin
            r_u1 <= ok ? r_rd_disp : '0;
            r_v1 <= ok ? r_rd_vel  : '0;
            r_w1 <= ok ? r_rd_acc  : '0;
            r_du <= du_hi ? SMAX[WORD_W-1:0] : (du_lo ? SMIN[WORD_W-1:0] : du_full[WORD_W-1:0]);
            if (upd && (du_hi || du_lo)) r_sat <= 1'b1;
        end
        if (i_cmd.mul_ld) begin
            r_neg <= op_a[WORD_W-1] ^ op_b[WORD_W-1];
            r_ma  <= op_a[WORD_W-1] ? -op_a : op_a;
            r_mb  <= op_b[WORD_W-1] ? -op_b : op_b;
            r_pp  <= '0;
        end
        if (i_cmd.pp_en) r_pp <= r_pp + pp_sh;
        if (i_cmd.rnd_en) begin
            r_prod <= r_neg ? -q_mag : q_mag;
            if (q_sat) r_sat <= 1'b1;
        end
        if (i_cmd.acc_en) begin
            r_sum <= s_next;
            if (i_cmd.uop.last) begin
                if (s_hi || s_lo) r_sat <= 1'b1;
                case (i_cmd.uop.dst)
                    D_DIAG:  r_diag <= s_clamp;
                    D_SM:    r_sm   <= s_clamp;
                    D_SD:    r_sd   <= s_clamp;
                    D_EFF:   r_eff  <= s_clamp;
                    D_ACC:   r_acc  <= s_clamp;
                    D_VEL:   r_vel  <= s_clamp;
                    default: ;
                endcase
            end
        end
    end

    // output word register
    logic r_out_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_data <= {r_vel, r_acc, r_diag, r_eff};
            o_out_user <= {r_sat, (r_func == F_EFF_LOAD) && r_cons};
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_stat.func    = r_func;
    assign o_stat.cons    = r_cons;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // a result is never loaded over one that is still waiting
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten");
    // clearing pass never overlaps item work
    a_clr_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_en |-> !(i_cmd.wb_en || i_cmd.mem_rd || i_cmd.load_in))
        else $error("clear overlaps item");
    // a waiting result word holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(o_out_data) && $stable(o_out_user)))
        else $error("waiting result changed");

endmodule
`default_nettype wire

### hdl/nbhu_ctrl.sv
// Controller: clearing pass, item sequencing and micro-program stepping.
`timescale 1ns / 1ps
`default_nettype none
module nbhu_ctrl #(
    parameter int DOF_DEPTH = 1024,
    parameter int AW        = 10
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire nbhu_pkg::t_stat i_stat,
    output nbhu_pkg::t_cmd       o_cmd,
    output logic [AW-1:0]        o_clr_addr
);
    import nbhu_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_WB    = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [2:0] PH_LD  = 3'd0;
    localparam logic [2:0] PH_RND = 3'd5;
    localparam logic [2:0] PH_ACC = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [2:0]        r_phase, n_phase;
    logic [STEP_W-1:0] r_step, n_step;
    logic [AW-1:0]     r_clr, n_clr;
    logic              r_upd, n_upd;
    t_uop              uop;
    logic              accept, is_calc;

    assign uop     = f_uop(r_upd, r_step);
    assign accept  = i_in_valid && o_in_ready;
    assign is_calc = (i_stat.func == F_EFF_LOAD) || (i_stat.func == F_UPDATE);

    // next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_step  = r_step;
        n_clr   = r_clr;
        n_upd   = r_upd;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DOF_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = S_READ;
            end
            S_READ: n_state = S_LOAD;
            S_LOAD: begin
                n_upd   = (i_stat.func == F_UPDATE);
                n_step  = '0;
                n_phase = PH_LD;
                n_state = is_calc ? S_MUL : S_WB;
            end
            S_MUL: begin
                if (r_phase == PH_ACC) begin
                    n_phase = PH_LD;
                    if (uop.stop || (uop.cut && i_stat.cons)) n_state = S_WB;
                    else n_step = r_step + STEP_W'(1);
                end else begin
                    n_phase = r_phase + 3'd1;
                end
            end
            S_WB: n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_phase <= PH_LD;
            r_step  <= '0;
            r_clr   <= '0;
            r_upd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_step  <= n_step;
            r_clr   <= n_clr;
            r_upd   <= n_upd;
        end
    end

    // commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.uop       = uop;
        o_cmd.load_in   = accept;
        o_cmd.mem_rd    = (r_state == S_READ);
        o_cmd.load_hist = (r_state == S_LOAD);
        o_cmd.mul_ld    = (r_state == S_MUL) && (r_phase == PH_LD);
        o_cmd.pp_en     = (r_state == S_MUL) && (r_phase != PH_LD) && (r_phase < PH_RND);
        o_cmd.pp_sel    = 2'(r_phase - 3'd1);
        o_cmd.rnd_en    = (r_state == S_MUL) && (r_phase == PH_RND);
        o_cmd.acc_en    = (r_state == S_MUL) && (r_phase == PH_ACC);
        o_cmd.wb_en     = (r_state == S_WB);
        o_cmd.out_load  = (r_state == S_DONE) && i_stat.out_free;
        o_cmd.clr_en    = (r_state == S_CLEAR);
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_clr_addr = r_clr;

    // no item is taken during the clearing pass
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("ready during clear");
    // an accepted word always starts a memory read next
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_READ))
        else $error("accept not followed by read");
    // the micro-program never runs past its end
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_step <= STEP_W'(9)))
        else $error("step out of range");

endmodule
`default_nettype wire

### hdl/newmark_beta_history_update.sv
// Top level of the Newmark-beta history update block.
`timescale 1ns / 1ps
`default_nettype none
// Keeps displacement, velocity and acceleration per degree of freedom in
// three DOF_DEPTH-deep memories and serves one input word at a time: init
// kinds load one history word, the effective-load kind returns the effective
// load and diagonal increment, the update kind computes the new acceleration
// and velocity and writes them back with the new displacement. After reset a
// clearing pass zeroes the memories with s_axis_tready low. All products go
// through one shared 48x48 multiplier built from 24x24 partial products. A
// new word is taken only after the previous result is loaded; the result
// sits in an output register so the next word is taken while it waits.
module newmark_beta_history_update #(
    parameter int DOF_DEPTH = 1024,
    parameter int FRAC_BITS = 24
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [47:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [159:0] s_axis_tdata,  // dof_index, constrained, value_a, value_b, value_c
    input  wire logic [2:0]   s_axis_tuser,  // func
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [191:0]      m_axis_tdata,  // eff_load, diag_add, new_acc, new_vel
    output logic [1:0]        m_axis_tuser   // skipped, saturated
);
    import nbhu_pkg::*;

    localparam int AW = (DOF_DEPTH > 1) ? $clog2(DOF_DEPTH) : 1;

    t_cmd          cmd;
    t_stat         stat;
    logic [AW-1:0] clr_addr;

    nbhu_ctrl #(.DOF_DEPTH(DOF_DEPTH), .AW(AW)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_clr_addr (clr_addr)
    );

    nbhu_datapath #(.DOF_DEPTH(DOF_DEPTH), .FRAC_BITS(FRAC_BITS), .AW(AW)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_func   (s_axis_tuser),
        .i_cmd       (cmd),
        .i_clr_addr  (clr_addr),
        .o_stat      (stat),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

endmodule
`default_nettype wire
